FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion on clk_i, quiet while rst_ni is low
`define ISMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form of the same
`define ISMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/isms_pkg.sv
package isms_pkg;

  localparam int unsigned ISMS_CAPACITY   = 16;
  localparam int unsigned ISMS_COORD_BITS = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QANY   = 2'd2,
    CMD_QALL   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_INV  = 2'd2
  } status_e;

  // what a cell does with its contents this cycle
  typedef enum logic [2:0] {
    OP_HOLD         = 3'd0,
    OP_PREV         = 3'd1,
    OP_NEXT         = 3'd2,
    OP_LOAD         = 3'd3,
    OP_TRIM_HI      = 3'd4,
    OP_TRIM_LO      = 3'd5,
    OP_PREV_TRIM_LO = 3'd6
  } cell_op_e;

  typedef struct packed {
    logic below;
    logic touch;
    logic overlap;
    logic covers;
    logic le_hi;
    logic split;
  } cell_flags_t;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] range_lo;
    logic [31:0] range_hi;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_lo;
    logic [31:0] found_hi;
    logic [32:0] covered_length;
    logic [4:0]  interval_total;
    status_e     status;
  } out_word_t;

endpackage

FILE: hdl/isms_cell.sv
module isms_cell import isms_pkg::*; #(
  parameter int unsigned CoordBits = ISMS_COORD_BITS
) (
  input  logic                 clk_i,
  input  cell_op_e             op_i,
  input  logic [CoordBits-1:0] lo_i,
  input  logic [CoordBits-1:0] hi_i,
  input  logic [CoordBits-1:0] wr_s_i,
  input  logic [CoordBits-1:0] wr_e_i,
  input  logic [CoordBits-1:0] prev_s_i,
  input  logic [CoordBits-1:0] prev_e_i,
  input  logic [CoordBits-1:0] next_s_i,
  input  logic [CoordBits-1:0] next_e_i,
  output logic [CoordBits-1:0] s_o,
  output logic [CoordBits-1:0] e_o,
  output cell_flags_t          flags_o
);

  logic [CoordBits-1:0] s_q, s_d, e_q, e_d;
  logic [CoordBits:0]   s_x, e_x, lo_x, hi_x;

  // next contents
  always_comb begin
    s_d = s_q;
    e_d = e_q;
    case (op_i)
      OP_PREV: begin
        s_d = prev_s_i;
        e_d = prev_e_i;
      end
      OP_NEXT: begin
        s_d = next_s_i;
        e_d = next_e_i;
      end
      OP_LOAD: begin
        s_d = wr_s_i;
        e_d = wr_e_i;
      end
      OP_TRIM_HI: e_d = lo_i - 1'b1;
      OP_TRIM_LO: s_d = hi_i + 1'b1;
      OP_PREV_TRIM_LO: begin
        s_d = hi_i + 1'b1;
        e_d = prev_e_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    e_q <= e_d;
  end

  // compares against the range, one bit wider so end plus one cannot wrap
  assign s_x  = {1'b0, s_q};
  assign e_x  = {1'b0, e_q};
  assign lo_x = {1'b0, lo_i};
  assign hi_x = {1'b0, hi_i};

  always_comb begin
    flags_o.below   = (e_x + 1'b1) < lo_x;
    flags_o.touch   = !((e_x + 1'b1) < lo_x) && !(s_x > (hi_x + 1'b1));
    flags_o.overlap = (e_q >= lo_i) && (s_q <= hi_i);
    flags_o.covers  = (s_q <= lo_i) && (e_q >= hi_i);
    flags_o.le_hi   = s_q <= hi_i;
    flags_o.split   = (s_q < lo_i) && (e_q > hi_i);
  end

  assign s_o = s_q;
  assign e_o = e_q;

endmodule

FILE: hdl/interval_set_merge_split.sv
// Sorted set of disjoint, non-touching closed intervals held in a row of cells, one interval
// per cell, with a running covered length. Each word gives one result word. After a word is
// taken, the evaluate state compares the range against every cell at once; queries, rejected
// ranges and adds already covered then go straight to the done state, which loads their result
// word into the output register.
// An add instead absorbs the stored intervals it touches one at a time, lowest first, and then
// inserts the merged interval; a remove trims, splits or deletes each overlapping interval in
// turn. The cell row moves contents one place when an interval is deleted or inserted. A new
// word is taken once the previous result is in the output register.
`include "assert_macros.svh"

module interval_set_merge_split import isms_pkg::*; #(
  parameter int unsigned CAPACITY   = ISMS_CAPACITY,
  parameter int unsigned COORD_BITS = ISMS_COORD_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned TotW = COORD_BITS + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_ADD  = 5'b00100,
    S_REM  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic [COORD_BITS-1:0] lo_q, hi_q, ms_q, ms_d, me_q, me_d;
  logic [COORD_BITS-1:0] flo_q, flo_d, fhi_q, fhi_d;
  logic                  hit_q, hit_d;
  status_e               st_q, st_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [TotW-1:0]       tot_q, tot_d;
  logic                  out_valid_q;
  out_word_t             out_q;
  logic                  in_acc;

  logic [COORD_BITS-1:0] cs [CAPACITY];
  logic [COORD_BITS-1:0] ce [CAPACITY];
  logic [COORD_BITS-1:0] ps [CAPACITY];
  logic [COORD_BITS-1:0] pe [CAPACITY];
  logic [COORD_BITS-1:0] ns [CAPACITY];
  logic [COORD_BITS-1:0] ne [CAPACITY];
  cell_flags_t           flags [CAPACITY];
  cell_op_e              op [CAPACITY];

  logic [CAPACITY-1:0] valid, v_touch, v_ov, v_cov, v_below, v_le, v_split;
  logic [CAPACITY-1:0] m_first, m_ge, m_last, m_sel, g_p, at_p, gt_p;
  logic [CntW:0]       k_touch;
  logic [COORD_BITS-1:0] sel_s, sel_e, cut_hi, cut_lo;
  logic [TotW-1:0]       cut_len;

  // cell row with neighbour links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign ps[i] = '0;
      assign pe[i] = '0;
    end else begin : g_mid
      assign ps[i] = cs[i-1];
      assign pe[i] = ce[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign ns[i] = '0;
      assign ne[i] = '0;
    end else begin : g_inner
      assign ns[i] = cs[i+1];
      assign ne[i] = ce[i+1];
    end

    isms_cell #(
      .CoordBits(COORD_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .op_i     (op[i]),
      .lo_i     (lo_q),
      .hi_i     (hi_q),
      .wr_s_i   (ms_q),
      .wr_e_i   (me_q),
      .prev_s_i (ps[i]),
      .prev_e_i (pe[i]),
      .next_s_i (ns[i]),
      .next_e_i (ne[i]),
      .s_o      (cs[i]),
      .e_o      (ce[i]),
      .flags_o  (flags[i])
    );

    assign valid[i]   = CntW'(i) < cnt_q;
    assign v_touch[i] = valid[i] & flags[i].touch;
    assign v_ov[i]    = valid[i] & flags[i].overlap;
    assign v_cov[i]   = valid[i] & flags[i].covers;
    assign v_below[i] = valid[i] & flags[i].below;
    assign v_le[i]    = valid[i] & flags[i].le_hi;
    assign v_split[i] = valid[i] & flags[i].split;
  end

  // position masks; flagged cells always form one contiguous run
  always_comb begin
    m_first = (state_q == S_ADD) ? (v_touch & ~(v_touch << 1)) : (v_ov & ~(v_ov << 1));
    m_ge    = ~(m_first - 1'b1);
    m_last  = v_le & ~(v_le >> 1);
    g_p     = ~v_below;
    at_p    = g_p & ~(g_p << 1);
    gt_p    = g_p & (g_p << 1);
    k_touch = (CntW + 1)'($countones(v_touch));
  end

  // pick the one cell marked in the select mask
  always_comb begin
    unique case (state_q)
      S_EVAL:  m_sel = (cmd_q == CMD_ADD) ? v_cov : m_last;
      default: m_sel = m_first;
    endcase
    sel_s = '0;
    sel_e = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_s = sel_s | (cs[i] & {COORD_BITS{m_sel[i]}});
      sel_e = sel_e | (ce[i] & {COORD_BITS{m_sel[i]}});
    end
  end

  // length cut out of the selected interval
  always_comb begin
    cut_hi  = (sel_e < hi_q) ? sel_e : hi_q;
    cut_lo  = (sel_s > lo_q) ? sel_s : lo_q;
    cut_len = TotW'(cut_hi) - TotW'(cut_lo) + 1'b1;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    tot_d   = tot_q;
    ms_d    = ms_q;
    me_d    = me_q;
    hit_d   = hit_q;
    flo_d   = flo_q;
    fhi_d   = fhi_q;
    st_d    = st_q;
    for (int i = 0; i < CAPACITY; i++) op[i] = OP_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_EVAL;
      end

      S_EVAL: begin
        hit_d   = 1'b0;
        flo_d   = '0;
        fhi_d   = '0;
        st_d    = ST_OK;
        state_d = S_DONE;
        if (lo_q > hi_q) begin
          st_d = ST_INV;
        end else begin
          case (cmd_q)
            CMD_ADD: begin
              if (|v_cov) begin
                flo_d = sel_s;
                fhi_d = sel_e;
              end else if (((CntW + 1)'(cnt_q) + 1'b1 - k_touch) >
                           (CntW + 1)'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                ms_d    = lo_q;
                me_d    = hi_q;
                state_d = S_ADD;
              end
            end
            CMD_REMOVE: begin
              if (|v_split && cnt_q == CntW'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                hit_d   = |v_ov;
                state_d = S_REM;
              end
            end
            default: begin
              if (|m_last) begin
                if (cmd_q == CMD_QANY ? (sel_e >= lo_q)
                                      : (sel_s <= lo_q && sel_e >= hi_q)) begin
                  hit_d = 1'b1;
                  flo_d = sel_s;
                  fhi_d = sel_e;
                end
              end
            end
          endcase
        end
      end

      S_ADD: begin
        if (|v_touch) begin
          // absorb the lowest touching interval and close the gap
          if (sel_s < ms_q) ms_d = sel_s;
          if (sel_e > me_q) me_d = sel_e;
          tot_d = tot_q - (TotW'(sel_e) - TotW'(sel_s) + 1'b1);
          cnt_d = cnt_q - 1'b1;
          for (int i = 0; i < CAPACITY; i++) if (m_ge[i]) op[i] = OP_NEXT;
        end else begin
          // insert the merged interval in order
          for (int i = 0; i < CAPACITY; i++) begin
            if (at_p[i]) op[i] = OP_LOAD;
            else if (gt_p[i]) op[i] = OP_PREV;
          end
          cnt_d   = cnt_q + 1'b1;
          tot_d   = tot_q + (TotW'(me_q) - TotW'(ms_q) + 1'b1);
          flo_d   = ms_q;
          fhi_d   = me_q;
          state_d = S_DONE;
        end
      end

      S_REM: begin
        if (|v_ov) begin
          tot_d = tot_q - cut_len;
          if (sel_s < lo_q && sel_e > hi_q) begin
            // split into a left and a right piece
            for (int i = 0; i < CAPACITY; i++) begin
              if (m_first[i]) op[i] = OP_TRIM_HI;
              else if (m_ge[i] && (i == 0 || !m_first[i-1])) op[i] = OP_PREV;
              else if (m_ge[i]) op[i] = OP_PREV_TRIM_LO;
            end
            cnt_d = cnt_q + 1'b1;
          end else if (sel_s < lo_q) begin
            for (int i = 0; i < CAPACITY; i++) if (m_first[i]) op[i] = OP_TRIM_HI;
          end else if (sel_e > hi_q) begin
            for (int i = 0; i < CAPACITY; i++) if (m_first[i]) op[i] = OP_TRIM_LO;
          end else begin
            for (int i = 0; i < CAPACITY; i++) if (m_ge[i]) op[i] = OP_NEXT;
            cnt_d = cnt_q - 1'b1;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // word and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_word_i.command;
      lo_q  <= COORD_BITS'(in_word_i.range_lo);
      hi_q  <= COORD_BITS'(in_word_i.range_hi);
    end
    ms_q  <= ms_d;
    me_q  <= me_d;
    hit_q <= hit_d;
    flo_q <= flo_d;
    fhi_q <= fhi_d;
    st_q  <= st_d;
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.hit            <= hit_q;
      out_q.found_lo       <= 32'(flo_q);
      out_q.found_hi       <= 32'(fhi_q);
      out_q.covered_length <= 33'(tot_q);
      out_q.interval_total <= 5'(cnt_q);
      out_q.status         <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  `ISMS_ASSERT(a_cnt_cap, cnt_q <= CntW'(CAPACITY), "interval count above capacity")
  `ISMS_ASSERT_IMP(a_cnt_step, 1'b1,
    cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1,
    "interval count moved by more than one")
  `ISMS_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(state_q) == S_DONE,
    "result word loaded outside the done state")
  `ISMS_ASSERT_IMP(a_acc_eval, in_acc, ##1 state_q == S_EVAL,
    "accepted word not evaluated next cycle")

endmodule
